FILE: rtl/apg_pkg.sv
// ----------------------------------------------------------------------------
// apg_pkg
// Shared types, register indexes, mode codes and LFSR constants for the
// axis pattern generator.
// ----------------------------------------------------------------------------
package apg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_SPEED         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LIMIT           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIMIT           = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_PAUSE_MS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_MIN_DISTANCE = 3'd6;

    // Axis modes
    localparam logic [1:0] MODE_HOLD   = 2'd0;
    localparam logic [1:0] MODE_SWEEP  = 2'd1;
    localparam logic [1:0] MODE_STEP   = 2'd2;
    localparam logic [1:0] MODE_RANDOM = 2'd3;

    // Register reset values
    localparam logic [1:0]         RST_AXIS_MODE           = MODE_HOLD;
    localparam logic [14:0]        RST_SWEEP_SPEED         = 15'd64;
    localparam logic [14:0]        RST_STEP_SIZE           = 15'd1024;
    localparam logic signed [15:0] RST_MIN_LIMIT           = -16'sd16384;
    localparam logic signed [15:0] RST_MAX_LIMIT           = 16'sd16384;
    localparam logic [15:0]        RST_RANDOM_PAUSE_MS     = 16'd1000;
    localparam logic [14:0]        RST_RANDOM_MIN_DISTANCE = 15'd2048;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef struct packed {
        logic [1:0]         axis_mode;
        logic [14:0]        sweep_speed;
        logic [14:0]        step_size;
        logic signed [15:0] min_limit;
        logic signed [15:0] max_limit;
        logic [15:0]        random_pause_ms;
        logic [14:0]        random_min_distance;
    } t_cfg;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic               hit;
        logic signed [15:0] target;
    } t_draw_status;

    // One shift of the Galois LFSR.
    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] sh;
        sh = s >> 1;
        return s[0] ? (sh ^ LFSR_TAPS) : sh;
    endfunction

endpackage

FILE: rtl/axis_pattern_generator_unit.sv
// ----------------------------------------------------------------------------
// axis_pattern_generator_unit
// Tick-driven motion pattern generator for one servo axis.
// ----------------------------------------------------------------------------
// Each input transfer is one tick and yields exactly one result transfer.
// A tick that loads, holds or finds its pause not yet elapsed goes from
// S_DECIDE straight to S_DONE. A sweep step passes through S_SWEEP and
// S_CLAMP. A random pick passes through S_RSTART and S_DRAW, then S_RFALL and
// S_RSAT if no draw hits. The draw search runs one LFSR draw per cycle through
// the shared multiplier and stops at the first target far enough away. The
// block takes one tick at a time; a finished result waits in the output
// register while the next tick is accepted. Configuration transfers are
// always accepted and are meant to be made while no tick is in flight.
module axis_pattern_generator_unit import apg_pkg::*; #(
    parameter int STEP_PAUSE_MS   = 1000,
    parameter int RANDOM_ATTEMPTS = 20,
    parameter int POSITION_WIDTH  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_load,
    input  logic signed [15:0]    i_load_value,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [15:0]    o_position,
    output logic                  o_direction_down,
    output logic                  o_moved,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int W  = POSITION_WIDTH;
    localparam int AW = ((W > 16) ? W : 16) + 2;
    localparam logic [31:0] STEP_PAUSE = 32'(STEP_PAUSE_MS);
    localparam logic signed [AW-1:0] POS_HI = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [AW-1:0] POS_LO = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_SWEEP  = 4'd2;
    localparam logic [3:0] S_CLAMP  = 4'd3;
    localparam logic [3:0] S_RSTART = 4'd4;
    localparam logic [3:0] S_DRAW   = 4'd5;
    localparam logic [3:0] S_RFALL  = 4'd6;
    localparam logic [3:0] S_RSAT   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    function automatic logic signed [W-1:0] sat_pos(input logic signed [AW-1:0] v);
        if (v > POS_HI) return POS_HI[W-1:0];
        if (v < POS_LO) return POS_LO[W-1:0];
        return v[W-1:0];
    endfunction

    t_cfg         cfg;
    t_draw_status draw_st;

    logic [3:0]          r_state,   n_state;
    logic [31:0]         r_now,     n_now;
    logic                r_load,    n_load;
    logic signed [15:0]  r_load_value, n_load_value;
    logic signed [W-1:0] r_pos,     n_pos;
    logic                r_down,    n_down;
    logic [31:0]         r_last,    n_last;
    logic                r_moved,   n_moved;
    logic                r_up_side, n_up_side;
    logic signed [AW-1:0] r_sum,    n_sum;
    logic                r_out_valid, n_out_valid;
    logic signed [15:0]  r_out_position, n_out_position;
    logic                r_out_down, n_out_down;
    logic                r_out_moved, n_out_moved;

    logic [31:0]          elapsed;
    logic signed [AW-1:0] pos_ext;
    logic signed [AW-1:0] min_ext;
    logic signed [AW-1:0] max_ext;
    logic signed [AW-1:0] load_ext;
    logic signed [AW-1:0] target_ext;
    logic [14:0]          add_mag;
    logic signed [AW-1:0] add_b;
    logic                 add_sub;
    logic signed [AW-1:0] sum_out;
    logic signed [AW-1:0] clamp_p;
    logic                 clamp_down;
    logic                 in_accept;
    logic                 draw_start;

    apg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    apg_draw_unit #(
        .POSITION_WIDTH  (POSITION_WIDTH),
        .RANDOM_ATTEMPTS (RANDOM_ATTEMPTS)
    ) u_draw (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (draw_start),
        .i_cur    (r_pos),
        .i_cfg    (cfg),
        .o_status (draw_st)
    );

    assign o_in_ready       = (r_state == S_IDLE);
    assign in_accept        = i_in_valid && o_in_ready;
    assign draw_start       = (r_state == S_RSTART);
    assign o_out_valid      = r_out_valid;
    assign o_position       = r_out_position;
    assign o_direction_down = r_out_down;
    assign o_moved          = r_out_moved;

    assign elapsed    = r_now - r_last;
    assign pos_ext    = {{(AW-W){r_pos[W-1]}}, r_pos};
    assign min_ext    = {{(AW-16){cfg.min_limit[15]}}, cfg.min_limit};
    assign max_ext    = {{(AW-16){cfg.max_limit[15]}}, cfg.max_limit};
    assign load_ext   = {{(AW-16){r_load_value[15]}}, r_load_value};
    assign target_ext = {{(AW-16){draw_st.target[15]}}, draw_st.target};

    // Shared adder: sweep increment in S_SWEEP, fallback distance otherwise.
    always_comb begin
        if (r_state == S_SWEEP) begin
            add_mag = (cfg.axis_mode == MODE_STEP) ? cfg.step_size : cfg.sweep_speed;
            add_sub = r_down;
        end else begin
            add_mag = cfg.random_min_distance;
            add_sub = !r_up_side;
        end
    end

    assign add_b   = {{(AW-15){1'b0}}, add_mag};
    assign sum_out = add_sub ? (pos_ext - add_b) : (pos_ext + add_b);

    // The max test comes first, so reversed limits settle at min moving up.
    always_comb begin
        clamp_p    = r_sum;
        clamp_down = r_down;
        if (clamp_p >= max_ext) begin
            clamp_p    = max_ext;
            clamp_down = 1'b1;
        end
        if (clamp_p <= min_ext) begin
            clamp_p    = min_ext;
            clamp_down = 1'b0;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_now          = r_now;
        n_load         = r_load;
        n_load_value   = r_load_value;
        n_pos          = r_pos;
        n_down         = r_down;
        n_last         = r_last;
        n_moved        = r_moved;
        n_up_side      = r_up_side;
        n_sum          = r_sum;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_position = r_out_position;
        n_out_down     = r_out_down;
        n_out_moved    = r_out_moved;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_now        = i_now_ms;
                    n_load       = i_load;
                    n_load_value = i_load_value;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_moved = 1'b0;
                n_state = S_DONE;
                if (r_load) begin
                    n_pos   = sat_pos(load_ext);
                    n_down  = 1'b0;
                    n_moved = 1'b1;
                end else begin
                    unique case (cfg.axis_mode)
                        MODE_HOLD: begin
                            n_moved = 1'b0;
                        end
                        MODE_SWEEP: begin
                            n_moved = 1'b1;
                            n_state = S_SWEEP;
                        end
                        MODE_STEP: begin
                            if (elapsed >= STEP_PAUSE) begin
                                n_last  = r_now;
                                n_moved = 1'b1;
                                n_state = S_SWEEP;
                            end
                        end
                        MODE_RANDOM: begin
                            if (elapsed >= {16'd0, cfg.random_pause_ms}) begin
                                n_last  = r_now;
                                n_moved = 1'b1;
                                if (cfg.max_limit > cfg.min_limit) begin
                                    n_state = S_RSTART;
                                end
                            end
                        end
                        default: n_moved = 1'b0;
                    endcase
                end
            end
            S_SWEEP: begin
                n_sum   = sum_out;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_pos   = sat_pos(clamp_p);
                n_down  = clamp_down;
                n_state = S_DONE;
            end
            S_RSTART: begin
                n_up_side = (pos_ext <<< 1) < (min_ext + max_ext);
                n_state   = S_DRAW;
            end
            S_DRAW: begin
                if (draw_st.done) begin
                    if (draw_st.hit) begin
                        n_pos   = sat_pos(target_ext);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RFALL;
                    end
                end
            end
            S_RFALL: begin
                n_sum   = sum_out;
                n_state = S_RSAT;
            end
            S_RSAT: begin
                n_pos   = sat_pos(r_sum);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid    = 1'b1;
                    n_out_position = pos_ext[15:0];
                    n_out_down     = r_down;
                    n_out_moved    = r_moved;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_down      <= 1'b0;
            r_last      <= '0;
            r_moved     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_down      <= n_down;
            r_last      <= n_last;
            r_moved     <= n_moved;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now          <= n_now;
        r_load         <= n_load;
        r_load_value   <= n_load_value;
        r_up_side      <= n_up_side;
        r_sum          <= n_sum;
        r_out_position <= n_out_position;
        r_out_down     <= n_out_down;
        r_out_moved    <= n_out_moved;
    end

    a_accept_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_DECIDE))
        else $error("accepted tick did not enter decision state");

    a_draw_done_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        draw_st.done |-> (r_state == S_DRAW))
        else $error("draw search finished outside the draw state");

    a_idle_draw_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !draw_st.busy)
        else $error("draw search still busy while idle");

    a_moving_states_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP || r_state == S_CLAMP || r_state == S_RSTART
         || r_state == S_DRAW || r_state == S_RFALL || r_state == S_RSAT) |-> r_moved)
        else $error("position update in progress without moved flag");

    a_result_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("finished tick did not reach the output register");

endmodule

FILE: rtl/apg_cfg_regs.sv
// ----------------------------------------------------------------------------
// apg_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module apg_cfg_regs import apg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_AXIS_MODE:           n_cfg.axis_mode           = i_cfg_data[1:0];
                CFG_SWEEP_SPEED:         n_cfg.sweep_speed         = i_cfg_data[14:0];
                CFG_STEP_SIZE:           n_cfg.step_size           = i_cfg_data[14:0];
                CFG_MIN_LIMIT:           n_cfg.min_limit           = i_cfg_data;
                CFG_MAX_LIMIT:           n_cfg.max_limit           = i_cfg_data;
                CFG_RANDOM_PAUSE_MS:     n_cfg.random_pause_ms     = i_cfg_data;
                CFG_RANDOM_MIN_DISTANCE: n_cfg.random_min_distance = i_cfg_data[14:0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis_mode           <= RST_AXIS_MODE;
            r_cfg.sweep_speed         <= RST_SWEEP_SPEED;
            r_cfg.step_size           <= RST_STEP_SIZE;
            r_cfg.min_limit           <= RST_MIN_LIMIT;
            r_cfg.max_limit           <= RST_MAX_LIMIT;
            r_cfg.random_pause_ms     <= RST_RANDOM_PAUSE_MS;
            r_cfg.random_min_distance <= RST_RANDOM_MIN_DISTANCE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/apg_draw_unit.sv
// ----------------------------------------------------------------------------
// apg_draw_unit
// Random target search: one LFSR draw per cycle through a shared registered
// multiplier, with the distance test in the cycle after each draw.
// ----------------------------------------------------------------------------
module apg_draw_unit import apg_pkg::*; #(
    parameter int POSITION_WIDTH  = 16,
    parameter int RANDOM_ATTEMPTS = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [POSITION_WIDTH-1:0] i_cur,
    input  t_cfg                             i_cfg,
    output t_draw_status                     o_status
);

    localparam int W     = POSITION_WIDTH;
    localparam int CNT_W = $clog2(RANDOM_ATTEMPTS + 1);
    localparam int DW    = ((W > 17) ? W : 17) + 2;
    localparam logic [CNT_W-1:0] ATTEMPTS = CNT_W'(RANDOM_ATTEMPTS);

    logic [15:0]        r_lfsr;
    logic [15:0]        r_range;
    logic signed [15:0] r_min;
    logic signed [W-1:0] r_cur;
    logic [14:0]        r_dist;
    logic [CNT_W-1:0]   r_issued;
    logic               r_prod_valid;
    logic [15:0]        r_prod;
    logic [15:0]        r_prod_lfsr;
    logic               r_busy;
    logic               r_done;
    logic               r_hit;
    logic signed [15:0] r_target;

    logic [15:0]         lfsr_next;
    logic [29:0]         prod_full;
    logic signed [DW-1:0] target_ext;
    logic signed [DW-1:0] cur_ext;
    logic signed [DW-1:0] dist_ext;
    logic signed [DW-1:0] diff;
    logic                issue_en;
    logic                hit;
    logic                last_miss;

    assign lfsr_next  = lfsr_step(r_lfsr);
    assign prod_full  = {16'd0, lfsr_next[13:0]} * {14'd0, r_range};
    assign target_ext = {{(DW-16){r_min[15]}}, r_min} + {{(DW-16){1'b0}}, r_prod};
    assign cur_ext    = {{(DW-W){r_cur[W-1]}}, r_cur};
    assign dist_ext   = {{(DW-15){1'b0}}, r_dist};
    assign diff       = target_ext - cur_ext;

    assign issue_en  = r_busy && (r_issued != ATTEMPTS);
    assign hit       = r_busy && r_prod_valid && (diff >= dist_ext || diff <= -dist_ext);
    assign last_miss = r_busy && r_prod_valid && !hit && !issue_en;

    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;
    assign o_status.hit    = r_hit;
    assign o_status.target = r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr       <= LFSR_SEED;
            r_busy       <= 1'b0;
            r_done       <= 1'b0;
            r_prod_valid <= 1'b0;
            r_issued     <= '0;
            r_hit        <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy       <= 1'b1;
                r_issued     <= '0;
                r_prod_valid <= 1'b0;
            end else if (r_busy) begin
                r_prod_valid <= issue_en;
                if (issue_en) begin
                    r_issued <= r_issued + 1'b1;
                end
                // On a hit the LFSR is rolled back to the state right after
                // the winning draw, discarding the draw issued meanwhile.
                if (hit) begin
                    r_lfsr <= r_prod_lfsr;
                end else if (issue_en) begin
                    r_lfsr <= lfsr_next;
                end
                if (hit || last_miss) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_hit  <= hit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_range <= 16'(i_cfg.max_limit - i_cfg.min_limit);
            r_min   <= i_cfg.min_limit;
            r_cur   <= i_cur;
            r_dist  <= i_cfg.random_min_distance;
        end
        if (issue_en) begin
            r_prod      <= prod_full[29:14];
            r_prod_lfsr <= lfsr_next;
        end
        if (hit) begin
            r_target <= target_ext[15:0];
        end
    end

endmodule
